// ===== hdl/assert_macros.svh =====
// Assertion helpers included by the encoder unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define RSPE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define RSPE_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hdl/rspe_pkg.sv =====
`timescale 1ns / 1ps

package rspe_pkg;

   localparam int PARITY_SYMBOLS  = 32;
   localparam int MESSAGE_SYMBOLS = 223;
   localparam int SYMBOL_W        = 8;
   localparam int COUNT_W         = 8;
   localparam int DRAIN_W         = $clog2(PARITY_SYMBOLS);

   // Low byte of the field polynomial x^8+x^7+x^2+x+1
   localparam logic [SYMBOL_W-1:0] FIELD_REDUCE = 8'h87;

   // Generator polynomial coefficients, highest degree first
   localparam logic [SYMBOL_W-1:0] GEN_COEF [0:PARITY_SYMBOLS] = '{
      8'd1,   8'd69,  8'd251, 8'd239, 8'd38,  8'd105, 8'd20,  8'd238,
      8'd218, 8'd114, 8'd188, 8'd229, 8'd112, 8'd139, 8'd85,  8'd64,
      8'd213, 8'd64,  8'd85,  8'd139, 8'd112, 8'd229, 8'd188, 8'd114,
      8'd218, 8'd238, 8'd20,  8'd105, 8'd38,  8'd239, 8'd251, 8'd69,
      8'd1
   };

   // Per-cycle control handed to every cell of the remainder chain
   typedef struct packed {
      logic load;   // fold a message symbol in
      logic shift;  // move one parity symbol toward the output
   } cell_ctrl_type;

   // GF(256) multiply, shift-and-add with reduction
   function automatic logic [SYMBOL_W-1:0] gf_mul(input logic [SYMBOL_W-1:0] x,
                                                  input logic [SYMBOL_W-1:0] y);
      logic [SYMBOL_W-1:0] acc;
      logic [SYMBOL_W-1:0] a;
      acc = '0;
      a   = x;
      for (int bit_idx = 0; bit_idx < SYMBOL_W; bit_idx++) begin
         if (y[bit_idx]) begin
            acc = acc ^ a;
         end
         if (a[SYMBOL_W-1]) begin
            a = {a[SYMBOL_W-2:0], 1'b0} ^ FIELD_REDUCE;
         end else begin
            a = {a[SYMBOL_W-2:0], 1'b0};
         end
      end
      return acc;
   endfunction

endpackage

// ===== hdl/rspe_cell.sv =====
`timescale 1ns / 1ps

module rspe_cell import rspe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cell_ctrl_type       ctrl,
   input  logic [SYMBOL_W-1:0] coef,
   input  logic [SYMBOL_W-1:0] feedback,
   input  logic [SYMBOL_W-1:0] neighbor,
   output logic [SYMBOL_W-1:0] value
);

   logic [SYMBOL_W-1:0] value_ff;
   logic [SYMBOL_W-1:0] value_in;

   // Fold the feedback term in, advance toward the output, or hold
   always_comb begin
      value_in = value_ff;
      if (ctrl.load) begin
         value_in = neighbor ^ gf_mul(coef, feedback);
      end else if (ctrl.shift) begin
         value_in = neighbor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
      end else begin
         value_ff <= value_in;
      end
   end

   assign value = value_ff;

endmodule

// ===== hdl/reed_solomon_parity_encoder_unit.sv =====
`timescale 1ns / 1ps
// A taken message symbol shows on the rsp_ port in the next cycle. Throughput: one
// message symbol per cycle while rsp_ready holds; after the last symbol of a codeword
// the 32 parity symbols leave at one per cycle, also while rsp_ready holds, with req_ready low.
// The 32-cell remainder chain does one fold or one shift per output symbol.
// Reset (synchronous, active high) clears the chain, counters and output valid.

module reed_solomon_parity_encoder_unit import rspe_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SYMBOL_W-1:0] req_message_symbol,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SYMBOL_W-1:0] rsp_code_symbol,
   output logic                rsp_is_parity,
   output logic                rsp_last
);

`include "assert_macros.svh"

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                drain_ff, drain_in;
   logic [DRAIN_W-1:0]  drain_cnt_ff, drain_cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SYMBOL_W-1:0] rsp_symbol_ff, rsp_symbol_in;
   logic                rsp_parity_ff, rsp_parity_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                slot_free;
   logic                req_take;
   logic                final_symbol;
   logic [SYMBOL_W-1:0] feedback;
   cell_ctrl_type       cell_ctrl;
   logic [SYMBOL_W-1:0] rem_value [0:PARITY_SYMBOLS-1];

   // Output register is free when empty or being taken
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready    = !drain_ff && slot_free;
   assign req_take     = req_valid && req_ready;
   assign final_symbol = ({1'b0, count_ff} + 9'd1) >= 9'(MESSAGE_SYMBOLS);
   assign feedback     = req_message_symbol ^ rem_value[0];

   assign cell_ctrl.load  = req_take;
   assign cell_ctrl.shift = drain_ff && slot_free;

   // Remainder chain: cell 0 holds the highest degree, zeros enter at the tail
   for (genvar gi = 0; gi < PARITY_SYMBOLS; gi++) begin : g_cell
      logic [SYMBOL_W-1:0] neighbor;
      if (gi == PARITY_SYMBOLS - 1) begin : g_tail
         assign neighbor = '0;
      end else begin : g_body
         assign neighbor = rem_value[gi + 1];
      end
      rspe_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (cell_ctrl),
         .coef     (GEN_COEF[gi + 1]),
         .feedback (feedback),
         .neighbor (neighbor),
         .value    (rem_value[gi])
      );
   end

   // Sequence message pass-through and parity drain
   always_comb begin
      count_in      = count_ff;
      drain_in      = drain_ff;
      drain_cnt_in  = drain_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_symbol_in = rsp_symbol_ff;
      rsp_parity_in = rsp_parity_ff;
      rsp_last_in   = rsp_last_ff;
      if (req_take) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = req_message_symbol;
         rsp_parity_in = 1'b0;
         rsp_last_in   = 1'b0;
         if (final_symbol) begin
            count_in     = '0;
            drain_in     = 1'b1;
            drain_cnt_in = '0;
         end else begin
            count_in = count_ff + COUNT_W'(1);
         end
      end else if (cell_ctrl.shift) begin
         rsp_valid_in  = 1'b1;
         rsp_symbol_in = rem_value[0];
         rsp_parity_in = 1'b1;
         rsp_last_in   = (drain_cnt_ff == DRAIN_W'(PARITY_SYMBOLS - 1));
         drain_cnt_in  = drain_cnt_ff + DRAIN_W'(1);
         if (drain_cnt_ff == DRAIN_W'(PARITY_SYMBOLS - 1)) begin
            drain_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         drain_ff     <= 1'b0;
         drain_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         drain_cnt_ff <= drain_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_symbol_ff <= rsp_symbol_in;
      rsp_parity_ff <= rsp_parity_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_code_symbol = rsp_symbol_ff;
   assign rsp_is_parity   = rsp_parity_ff;
   assign rsp_last        = rsp_last_ff;

   `RSPE_ASSERT(a_no_take_in_drain, (req_valid && req_ready) |-> !drain_ff, "item taken during parity drain")
   `RSPE_ASSERT(a_last_is_parity, (rsp_valid && rsp_last) |-> rsp_is_parity, "last flag on a message symbol")
   `RSPE_ASSERT(a_drain_starts_clean, $rose(drain_ff) |-> (count_ff == '0 && drain_cnt_ff == '0), "drain started with stale counters")
   `RSPE_ASSERT(a_last_ends_drain, (rsp_valid_ff && rsp_last_ff && !drain_ff) |-> (rem_value[0] == '0 && rem_value[PARITY_SYMBOLS-1] == '0), "chain not cleared after parity drain")
   `RSPE_ASSERT_ALWAYS(a_reset_clears, reset |=> (!rsp_valid_ff && !drain_ff), "reset left output or drain active")

endmodule
